[rtl/faa_pkg.sv]
// ----------------------------------------------------------------------------
// Field-aligned anisotropy package
// Shared constants for the field-aligned anisotropy pipeline.
// ----------------------------------------------------------------------------
package faa_pkg;

    // Default width of one signed Q16.16 input word.
    localparam int DEF_WORD_WIDTH = 32;

    // The anisotropy is (T*S - 3*Q) / Q scaled by one half of the fixed-point unit.
    localparam int ANISO_SHIFT = 15;

    // Pressure tensor element for row i, column j of the symmetric tensor,
    // with the elements ordered xx, xy, xz, yy, yz, zz.
    localparam int PIDX [3][3] = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};

endpackage

[rtl/field_aligned_anisotropy_top.sv]
// ----------------------------------------------------------------------------
// Field-aligned anisotropy pipeline
// Field and speed magnitudes, field-aligned velocity split and pressure
// anisotropy for one grid cell per beat.
// ----------------------------------------------------------------------------
// The block takes one cell per clock cycle while its skid entry is empty,
// and keeps no state from cell to cell. The pipeline depth is set by the
// square root and divider stages, which each produce one result bit per
// register stage: field and speed roots run beside the anisotropy divider,
// followed by the parallel-velocity divider and the root of the perpendicular
// speed. An output register with a skid entry keeps the input side open
// while a result waits to be taken. All words are signed Q16.16; magnitudes
// saturate at the largest positive value and signed results at the signed
// range. m_tuser flags a cell with zero field or zero parallel pressure; its
// anisotropy then reads zero, and with zero field so do the velocity split
// outputs.
module field_aligned_anisotropy_top
    import faa_pkg::*;
#(
    parameter int WORD_WIDTH = DEF_WORD_WIDTH,
    localparam int IN_W = ((12 * WORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((5 * WORD_WIDTH - 3 + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // field_x, field_y, field_z, vel_x, vel_y, vel_z,
    // press_xx, press_xy, press_xz, press_yy, press_yz, press_zz
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // field_mag, anisotropy, vel_mag, vel_parallel, vel_perp
    output logic [OUT_W-1:0] m_tdata,
    // invalid
    output logic [0:0]       m_tuser
);

    localparam int W    = WORD_WIDTH;
    localparam int P2   = 2 * W;
    localparam int DW   = 2 * W + 1;
    localparam int WW   = 2 * W + 2;
    localparam int TW   = W + 2;
    localparam int TSW  = 2 * W + 3;
    localparam int QW   = 3 * W + 3;
    localparam int QMW  = QW - 1;
    localparam int NUMW = 3 * W + 5;
    localparam int NMW  = NUMW - 1;
    localparam int NSW  = NMW + ANISO_SHIFT;
    localparam int LAT  = 3 * W + 14;

    localparam logic [W-1:0] SMAX_V = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0] SMIN_V = {1'b1, {(W - 1){1'b0}}};

    typedef struct packed {
        logic [W:0]    rem;
        logic [W-1:0]  root;
        logic [P2-1:0] x;
    } sq_t;

    typedef struct packed {
        logic [QMW-1:0] rem;
        logic [W:0]     quo;
        logic [W:0]     nb;
    } ad_t;

    typedef struct packed {
        logic [W-1:0] rem;
        logic [W-1:0] quo;
        logic [W-1:0] nb;
    } vd_t;

    typedef struct packed {
        logic [W-2:0] field_mag;
        logic [W-1:0] aniso;
        logic [W-2:0] vel_mag;
        logic         fz;
        logic         invalid;
    } part_t;

    typedef struct packed {
        sq_t            ss;
        sq_t            us;
        ad_t            ad;
        logic [QMW-1:0] qd;
        logic [P2-1:0]  su;
        logic [P2-1:0]  d_mag;
        logic           d_neg;
        logic           a_sat;
        logic           a_neg;
        logic           q_zero;
    } pb_t;

    typedef struct packed {
        vd_t           vd;
        logic [W-1:0]  fmag;
        logic [P2-1:0] su;
        logic          v_sat;
        logic          d_neg;
        part_t         part;
    } pc_t;

    typedef struct packed {
        logic [W-1:0]  vpar;
        logic [P2-1:0] sq;
        logic [P2-1:0] su;
        part_t         part;
    } pd_t;

    typedef struct packed {
        sq_t          ss;
        logic [W-1:0] vpar;
        part_t        part;
    } pe_t;

    typedef struct packed {
        logic [W-2:0] vel_perp;
        logic [W-1:0] vel_par;
        logic [W-2:0] vel_mag;
        logic [W-1:0] aniso;
        logic [W-2:0] field_mag;
        logic         invalid;
    } out_t;

    // One bit of an integer square root: two radicand bits enter per step.
    function automatic sq_t sq_step(input sq_t a);
        logic [W+2:0] r2;
        logic [W+2:0] tr;
        sq_t o;
        r2 = {a.rem, a.x[P2-1 -: 2]};
        tr = {1'b0, a.root, 2'b01};
        o.x = {a.x[P2-3:0], 2'b00};
        if (r2 >= tr) begin
            o.rem = (W + 1)'(r2 - tr);
            o.root = {a.root[W-2:0], 1'b1};
        end else begin
            o.rem = r2[W:0];
            o.root = {a.root[W-2:0], 1'b0};
        end
        return o;
    endfunction

    // One quotient bit of the anisotropy division.
    function automatic ad_t ad_step(input ad_t a, input logic [QMW-1:0] dv);
        logic [QMW:0] r2;
        ad_t o;
        r2 = {a.rem, a.nb[W]};
        o.nb = {a.nb[W-1:0], 1'b0};
        if (r2 >= {1'b0, dv}) begin
            o.rem = QMW'(r2 - {1'b0, dv});
            o.quo = {a.quo[W-1:0], 1'b1};
        end else begin
            o.rem = r2[QMW-1:0];
            o.quo = {a.quo[W-1:0], 1'b0};
        end
        return o;
    endfunction

    // One quotient bit of the parallel velocity division.
    function automatic vd_t vd_step(input vd_t a, input logic [W-1:0] dv);
        logic [W:0] r2;
        vd_t o;
        r2 = {a.rem, a.nb[W-1]};
        o.nb = {a.nb[W-2:0], 1'b0};
        if (r2 >= {1'b0, dv}) begin
            o.rem = W'(r2 - {1'b0, dv});
            o.quo = {a.quo[W-2:0], 1'b1};
        end else begin
            o.rem = r2[W-1:0];
            o.quo = {a.quo[W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [W-2:0] usat(input logic [W-1:0] v);
        return v[W-1] ? {(W - 1){1'b1}} : v[W-2:0];
    endfunction

    function automatic logic [W-1:0] ssat(input logic [W:0] m, input logic sat,
                                          input logic neg);
        logic [W:0]   neg_m;
        logic [W-1:0] r;
        neg_m = (W + 1)'(0) - m;
        if (sat) begin
            r = neg ? SMIN_V : SMAX_V;
        end else if (!neg) begin
            r = (m > {1'b0, SMAX_V}) ? SMAX_V : m[W-1:0];
        end else begin
            r = (m > {1'b0, SMIN_V}) ? SMIN_V : neg_m[W-1:0];
        end
        return r;
    endfunction

    logic en;
    logic [LAT-1:0] vld_reg;

    // Front stages: products, sums and the anisotropy numerator.
    logic signed [W-1:0]    b0_reg [3];
    logic signed [W-1:0]    u0_reg [3];
    logic signed [W-1:0]    p0_reg [6];
    logic signed [P2-1:0]   bb1_reg [3];
    logic signed [P2-1:0]   uu1_reg [3];
    logic signed [P2-1:0]   bu1_reg [3];
    logic signed [P2-1:0]   bp1_reg [3][3];
    logic signed [TW-1:0]   t1_reg;
    logic signed [W-1:0]    b1_reg [3];
    logic [P2-1:0]          s2_reg, su2_reg;
    logic signed [DW-1:0]   d2_reg;
    logic signed [WW-1:0]   w2_reg [3];
    logic signed [TW-1:0]   t2_reg;
    logic signed [W-1:0]    b2_reg [3];
    logic signed [WW-1:0]   bwh3_reg [3];
    logic signed [DW-1:0]   bwl3_reg [3];
    logic signed [TSW-1:0]  tsh3_reg, tsl3_reg;
    logic [P2-1:0]          s3_reg, su3_reg;
    logic signed [DW-1:0]   d3_reg;
    logic signed [QW-1:0]   bw4_reg [3];
    logic signed [NUMW-1:0] ts4_reg;
    logic [P2-1:0]          s4_reg, su4_reg;
    logic signed [DW-1:0]   d4_reg;
    logic signed [QW-1:0]   q5_reg;
    logic signed [NUMW-1:0] ts5_reg;
    logic [P2-1:0]          s5_reg, su5_reg;
    logic signed [DW-1:0]   d5_reg;
    logic signed [QW-1:0]   q6_reg;
    logic signed [NUMW-1:0] q36_reg, ts6_reg;
    logic [P2-1:0]          s6_reg, su6_reg;
    logic signed [DW-1:0]   d6_reg;
    logic signed [QW-1:0]   q7_reg;
    logic signed [NUMW-1:0] num7_reg;
    logic [P2-1:0]          s7_reg, su7_reg;
    logic signed [DW-1:0]   d7_reg;
    logic                   num_neg8_reg, q_neg8_reg, q_zero8_reg, d_neg8_reg;
    logic [NMW-1:0]         num_mag8_reg;
    logic [QMW-1:0]         q_mag8_reg;
    logic [P2-1:0]          d_mag8_reg, s8_reg, su8_reg;

    logic [NUMW-1:0] num_abs;
    logic [QW-1:0]   q_abs;
    logic [DW-1:0]   d_abs;
    logic [NSW-1:0]  nsh;
    logic [QMW-1:0]  a_hi;
    logic [W-1:0]    v_hi;
    logic [W-1:0]    qc;
    logic [W-1:0]    c_fmag;
    logic [W-1:0]    c_vmag;
    logic            c_invalid;

    pb_t pb_reg  [W+2];
    pb_t pb_next [W+2];
    pc_t pc_reg  [W+1];
    pc_t pc_next [W+1];
    pd_t pd_reg, pd_next;
    pe_t pe_reg  [W+1];
    pe_t pe_next [W+1];

    out_t res;
    out_t out_reg, skid_reg;
    logic out_valid_reg, skid_valid_reg;

    assign en = !skid_valid_reg;
    assign s_tready = en;

    assign num_abs = num7_reg[NUMW-1] ? NUMW'(0) - num7_reg : num7_reg;
    assign q_abs   = q7_reg[QW-1] ? QW'(0) - q7_reg : q7_reg;
    assign d_abs   = d7_reg[DW-1] ? DW'(0) - d7_reg : d7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                b0_reg[i] <= $signed(s_tdata[i*W +: W]);
                u0_reg[i] <= $signed(s_tdata[(3+i)*W +: W]);
            end
            for (int i = 0; i < 6; i++) begin
                p0_reg[i] <= $signed(s_tdata[(6+i)*W +: W]);
            end

            for (int i = 0; i < 3; i++) begin
                bb1_reg[i] <= P2'(b0_reg[i]) * P2'(b0_reg[i]);
                uu1_reg[i] <= P2'(u0_reg[i]) * P2'(u0_reg[i]);
                bu1_reg[i] <= P2'(b0_reg[i]) * P2'(u0_reg[i]);
                for (int j = 0; j < 3; j++) begin
                    bp1_reg[i][j] <= P2'(b0_reg[j]) * P2'(p0_reg[PIDX[i][j]]);
                end
            end
            t1_reg <= TW'(p0_reg[0]) + TW'(p0_reg[3]) + TW'(p0_reg[5]);
            b1_reg <= b0_reg;

            s2_reg  <= $unsigned(bb1_reg[0]) + $unsigned(bb1_reg[1]) + $unsigned(bb1_reg[2]);
            su2_reg <= $unsigned(uu1_reg[0]) + $unsigned(uu1_reg[1]) + $unsigned(uu1_reg[2]);
            d2_reg  <= DW'(bu1_reg[0]) + DW'(bu1_reg[1]) + DW'(bu1_reg[2]);
            for (int i = 0; i < 3; i++) begin
                w2_reg[i] <= WW'(bp1_reg[i][0]) + WW'(bp1_reg[i][1]) + WW'(bp1_reg[i][2]);
            end
            t2_reg <= t1_reg;
            b2_reg <= b1_reg;

            // Wide products are split at bit W into a signed upper and an
            // unsigned lower partial product.
            for (int i = 0; i < 3; i++) begin
                bwh3_reg[i] <= WW'(b2_reg[i]) * WW'($signed(w2_reg[i][WW-1:W]));
                bwl3_reg[i] <= DW'(b2_reg[i]) * DW'($signed({1'b0, w2_reg[i][W-1:0]}));
            end
            tsh3_reg <= TSW'(t2_reg) * TSW'($signed({1'b0, s2_reg[P2-1:W]}));
            tsl3_reg <= TSW'(t2_reg) * TSW'($signed({1'b0, s2_reg[W-1:0]}));
            s3_reg  <= s2_reg;
            su3_reg <= su2_reg;
            d3_reg  <= d2_reg;

            for (int i = 0; i < 3; i++) begin
                bw4_reg[i] <= (QW'(bwh3_reg[i]) <<< W) + QW'(bwl3_reg[i]);
            end
            ts4_reg <= (NUMW'(tsh3_reg) <<< W) + NUMW'(tsl3_reg);
            s4_reg  <= s3_reg;
            su4_reg <= su3_reg;
            d4_reg  <= d3_reg;

            q5_reg  <= bw4_reg[0] + bw4_reg[1] + bw4_reg[2];
            ts5_reg <= ts4_reg;
            s5_reg  <= s4_reg;
            su5_reg <= su4_reg;
            d5_reg  <= d4_reg;

            q36_reg <= NUMW'(q5_reg) + (NUMW'(q5_reg) <<< 1);
            q6_reg  <= q5_reg;
            ts6_reg <= ts5_reg;
            s6_reg  <= s5_reg;
            su6_reg <= su5_reg;
            d6_reg  <= d5_reg;

            num7_reg <= ts6_reg - q36_reg;
            q7_reg   <= q6_reg;
            s7_reg   <= s6_reg;
            su7_reg  <= su6_reg;
            d7_reg   <= d6_reg;

            num_neg8_reg <= num7_reg[NUMW-1];
            num_mag8_reg <= num_abs[NMW-1:0];
            q_neg8_reg   <= q7_reg[QW-1];
            q_mag8_reg   <= q_abs[QMW-1:0];
            q_zero8_reg  <= (q7_reg == '0);
            d_neg8_reg   <= d7_reg[DW-1];
            d_mag8_reg   <= d_abs[P2-1:0];
            s8_reg       <= s7_reg;
            su8_reg      <= su7_reg;
        end
    end

    // Root and anisotropy division stages. A quotient that needs more than
    // W+1 bits is caught up front, so only the low bits are iterated.
    assign nsh  = {num_mag8_reg, {ANISO_SHIFT{1'b0}}};
    assign a_hi = QMW'(nsh[NSW-1:W+1]);

    always_comb begin
        pb_next[0].ss.rem  = '0;
        pb_next[0].ss.root = '0;
        pb_next[0].ss.x    = s8_reg;
        pb_next[0].us.rem  = '0;
        pb_next[0].us.root = '0;
        pb_next[0].us.x    = su8_reg;
        pb_next[0].ad.rem  = a_hi;
        pb_next[0].ad.quo  = '0;
        pb_next[0].ad.nb   = nsh[W:0];
        pb_next[0].qd      = q_mag8_reg;
        pb_next[0].su      = su8_reg;
        pb_next[0].d_mag   = d_mag8_reg;
        pb_next[0].d_neg   = d_neg8_reg;
        pb_next[0].a_sat   = (a_hi >= q_mag8_reg);
        pb_next[0].a_neg   = num_neg8_reg ^ q_neg8_reg;
        pb_next[0].q_zero  = q_zero8_reg;
        for (int k = 1; k <= W + 1; k++) begin
            pb_next[k] = pb_reg[k-1];
            if (k <= W) begin
                pb_next[k].ss = sq_step(pb_reg[k-1].ss);
                pb_next[k].us = sq_step(pb_reg[k-1].us);
            end
            pb_next[k].ad = ad_step(pb_reg[k-1].ad, pb_reg[k-1].qd);
        end
    end

    // Parallel velocity division stages.
    assign c_fmag    = pb_reg[W+1].ss.root;
    assign c_vmag    = pb_reg[W+1].us.root;
    assign c_invalid = (c_fmag == '0) || pb_reg[W+1].q_zero;
    assign v_hi      = pb_reg[W+1].d_mag[P2-1:W];

    always_comb begin
        pc_next[0].vd.rem          = v_hi;
        pc_next[0].vd.quo          = '0;
        pc_next[0].vd.nb           = pb_reg[W+1].d_mag[W-1:0];
        pc_next[0].fmag            = c_fmag;
        pc_next[0].su              = pb_reg[W+1].su;
        pc_next[0].v_sat           = (v_hi >= c_fmag);
        pc_next[0].d_neg           = pb_reg[W+1].d_neg;
        pc_next[0].part.field_mag  = usat(c_fmag);
        pc_next[0].part.vel_mag    = usat(c_vmag);
        pc_next[0].part.fz         = (c_fmag == '0);
        pc_next[0].part.invalid    = c_invalid;
        pc_next[0].part.aniso      = c_invalid ? '0 :
            ssat(pb_reg[W+1].ad.quo, pb_reg[W+1].a_sat, pb_reg[W+1].a_neg);
        for (int k = 1; k <= W; k++) begin
            pc_next[k]    = pc_reg[k-1];
            pc_next[k].vd = vd_step(pc_reg[k-1].vd, pc_reg[k-1].fmag);
        end
    end

    // Parallel speed squared, clamped to the word range before squaring.
    assign qc = pc_reg[W].v_sat ? {W{1'b1}} : pc_reg[W].vd.quo;

    always_comb begin
        pd_next.vpar = ssat({1'b0, pc_reg[W].vd.quo}, pc_reg[W].v_sat, pc_reg[W].d_neg);
        pd_next.sq   = P2'(qc) * P2'(qc);
        pd_next.su   = pc_reg[W].su;
        pd_next.part = pc_reg[W].part;
    end

    // Perpendicular speed root stages.
    always_comb begin
        pe_next[0].ss.rem  = '0;
        pe_next[0].ss.root = '0;
        pe_next[0].ss.x    = (pd_reg.su > pd_reg.sq) ? pd_reg.su - pd_reg.sq : '0;
        pe_next[0].vpar    = pd_reg.vpar;
        pe_next[0].part    = pd_reg.part;
        for (int k = 1; k <= W; k++) begin
            pe_next[k]    = pe_reg[k-1];
            pe_next[k].ss = sq_step(pe_reg[k-1].ss);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= W + 1; k++) begin
                pb_reg[k] <= pb_next[k];
            end
            for (int k = 0; k <= W; k++) begin
                pc_reg[k] <= pc_next[k];
                pe_reg[k] <= pe_next[k];
            end
            pd_reg <= pd_next;
        end
    end

    always_comb begin
        res.field_mag = pe_reg[W].part.field_mag;
        res.aniso     = pe_reg[W].part.aniso;
        res.vel_mag   = pe_reg[W].part.vel_mag;
        res.vel_par   = pe_reg[W].part.fz ? '0 : pe_reg[W].vpar;
        res.vel_perp  = pe_reg[W].part.fz ? '0 : usat(pe_reg[W].ss.root);
        res.invalid   = pe_reg[W].part.invalid;
    end

    // Output register and skid entry. The pipeline halts only while the
    // skid entry holds a beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= vld_reg[LAT-1];
        end else if (vld_reg[LAT-1]) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || m_tready) begin
            out_reg <= res;
        end else begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_reg.vel_perp, out_reg.vel_par, out_reg.vel_mag,
                              out_reg.aniso, out_reg.field_mag});
    assign m_tuser  = out_reg.invalid;

endmodule

[sim/field_aligned_anisotropy_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Field-aligned anisotropy pipeline testbench
// Streams grid cells through the block, predicts every result with a wide
// integer model of the field, velocity and pressure arithmetic, and compares
// each result beat field by field under varying source and sink idling.
// ----------------------------------------------------------------------------
module field_aligned_anisotropy_top_tb;
    import faa_pkg::*;

    localparam int W = DEF_WORD_WIDTH;
    localparam int IN_W = ((12 * W + 7) / 8) * 8;
    localparam int OUT_W = ((5 * W - 3 + 7) / 8) * 8;
    localparam int LATENCY = 3 * W + 15;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [63:0] SMAX = 64'h7FFF_FFFF;

    typedef logic [W-1:0] cell_t [12];

    typedef struct packed {
        logic [W-2:0] field_mag;
        logic [W-1:0] anisotropy;
        logic [W-2:0] vel_mag;
        logic [W-1:0] vel_parallel;
        logic [W-2:0] vel_perp;
        logic         invalid;
    } cell_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [0:0]       m_tuser;

    cell_result_t expected_results [$];
    int  accepted_cells = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    int  src_idle_pct = 0;
    int  sink_stall_pct = 0;
    int  hold_seq = 0;
    int  hold_seen = 0;
    int  hold_left = 0;

    field_aligned_anisotropy_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [W-1:0] sat_signed(input logic signed [255:0] v);
        if (v > $signed(256'(SMAX))) return SMAX[W-1:0];
        if (v < -$signed(256'(SMAX)) - 1) return {1'b1, {(W-1){1'b0}}};
        return v[W-1:0];
    endfunction

    function automatic cell_result_t predict_cell(input cell_t c);
        cell_result_t r;
        logic signed [255:0] b [3];
        logic signed [255:0] u [3];
        logic signed [255:0] p [6];
        logic signed [255:0] s, su, d, q, t, num, aniso, fmag_w, dmag, vq, vp;
        logic [63:0] fmag, vmag, qc, sq;
        s = 0; su = 0; d = 0; q = 0;
        for (int i = 0; i < 3; i++) begin
            b[i] = $signed(c[i]);
            u[i] = $signed(c[3 + i]);
        end
        for (int k = 0; k < 6; k++) p[k] = $signed(c[6 + k]);
        for (int i = 0; i < 3; i++) begin
            s = s + b[i] * b[i];
            su = su + u[i] * u[i];
            d = d + b[i] * u[i];
        end
        fmag = isqrt64(s[63:0]);
        vmag = isqrt64(su[63:0]);
        r = '0;
        r.field_mag = (fmag > SMAX) ? SMAX[W-2:0] : fmag[W-2:0];
        r.vel_mag = (vmag > SMAX) ? SMAX[W-2:0] : vmag[W-2:0];
        if (s == 0) begin
            r.invalid = 1'b1;
            return r;
        end
        // The parallel speed divides by the unsaturated field magnitude.
        fmag_w = $signed({192'd0, fmag});
        dmag = (d < 0) ? -d : d;
        vq = dmag / fmag_w;
        vp = (d < 0) ? -vq : vq;
        r.vel_parallel = sat_signed(vp);
        qc = (vq > 256'h0_FFFF_FFFF) ? 64'hFFFF_FFFF : vq[63:0];
        sq = qc * qc;
        if (su[63:0] > sq) begin
            vmag = isqrt64(su[63:0] - sq);
            r.vel_perp = (vmag > SMAX) ? SMAX[W-2:0] : vmag[W-2:0];
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                q = q + b[i] * b[j] * p[PIDX[i][j]];
        if (q == 0) begin
            r.invalid = 1'b1;
            return r;
        end
        t = p[0] + p[3] + p[5];
        num = (t * s - 3 * q) * (256'sd1 <<< ANISO_SHIFT);
        // Signed division truncates toward zero, as the block does.
        aniso = num / q;
        r.anisotropy = sat_signed(aniso);
        return r;
    endfunction

    // Input side: record every accepted cell and its predicted result.
    always @(posedge aclk) begin
        cell_t c;
        if (aresetn && s_tvalid && s_tready) begin
            for (int k = 0; k < 12; k++) c[k] = s_tdata[W*k +: W];
            expected_results.push_back(predict_cell(c));
            accepted_cells++;
        end
    end

    // Output side: compare each result beat with the oldest prediction.
    always @(posedge aclk) begin
        cell_result_t e;
        cell_result_t a;
        if (aresetn && m_tvalid && m_tready) begin
            a.field_mag = m_tdata[0 +: 31];
            a.anisotropy = m_tdata[31 +: 32];
            a.vel_mag = m_tdata[63 +: 31];
            a.vel_parallel = m_tdata[94 +: 32];
            a.vel_perp = m_tdata[126 +: 31];
            a.invalid = m_tuser[0];
            if (expected_results.size() == 0) begin
                $error("result beat with no cell pending");
                error_count++;
            end else begin
                e = expected_results.pop_front();
                if (a.field_mag !== e.field_mag) begin
                    $error("field_mag: expected %h, got %h", e.field_mag, a.field_mag);
                    error_count++;
                end
                if (a.anisotropy !== e.anisotropy) begin
                    $error("anisotropy: expected %h, got %h", e.anisotropy, a.anisotropy);
                    error_count++;
                end
                if (a.vel_mag !== e.vel_mag) begin
                    $error("vel_mag: expected %h, got %h", e.vel_mag, a.vel_mag);
                    error_count++;
                end
                if (a.vel_parallel !== e.vel_parallel) begin
                    $error("vel_parallel: expected %h, got %h", e.vel_parallel, a.vel_parallel);
                    error_count++;
                end
                if (a.vel_perp !== e.vel_perp) begin
                    $error("vel_perp: expected %h, got %h", e.vel_perp, a.vel_perp);
                    error_count++;
                end
                if (a.invalid !== e.invalid) begin
                    $error("invalid: expected %b, got %b", e.invalid, a.invalid);
                    error_count++;
                end
            end
        end
    end

    // Sink readiness, with a long hold-off whenever one is requested.
    always @(negedge aclk) begin
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_cell(input cell_t c);
        int n;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        for (int k = 0; k < 12; k++) s_tdata[W*k +: W] = c[k];
        s_tvalid = 1'b1;
        n = accepted_cells;
        do @(negedge aclk); while (accepted_cells == n);
    endtask

    function automatic logic [W-1:0] rand_word();
        logic [W-1:0] v;
        case ($urandom_range(9))
            0, 1: v = $urandom;
            2: v = '0;
            3: v = 32'h7FFF_FFFF;
            4: v = 32'h8000_0000;
            default: begin
                v = $urandom >> $urandom_range(31, 8);
                if ($urandom_range(1)) v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic cell_t rand_cell();
        cell_t c;
        int kind;
        kind = $urandom_range(19);
        for (int k = 0; k < 12; k++) c[k] = rand_word();
        if (kind == 0) begin
            c[0] = '0; c[1] = '0; c[2] = '0;
        end else if (kind == 1) begin
            for (int k = 6; k < 12; k++) c[k] = '0;
        end else if (kind == 2) begin
            // Field along x with no xx pressure gives a zero parallel term.
            c[1] = '0; c[2] = '0; c[6] = '0;
        end else if (kind < 10) begin
            // Moderate, physically shaped cell: positive diagonal pressure.
            for (int k = 0; k < 6; k++) c[k] = $signed(16'($urandom)) <<< $urandom_range(10);
            c[6] = $urandom_range(32'h00FF_FFFF, 1);
            c[9] = $urandom_range(32'h00FF_FFFF, 1);
            c[11] = $urandom_range(32'h00FF_FFFF, 1);
            c[7] = $signed(12'($urandom)) <<< 8;
            c[8] = $signed(12'($urandom)) <<< 8;
            c[10] = $signed(12'($urandom)) <<< 8;
        end
        return c;
    endfunction

    function automatic cell_t fill_cell(input logic [W-1:0] v);
        cell_t c;
        for (int k = 0; k < 12; k++) c[k] = v;
        return c;
    endfunction

    task automatic test_directed();
        cell_t c;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        send_cell(fill_cell(32'h7FFF_FFFF));
        send_cell(fill_cell(32'h8000_0000));
        send_cell(fill_cell(32'h0000_0000));
        send_cell(fill_cell(32'hFFFF_FFFF));
        send_cell(fill_cell(32'h0001_0000));
        // Zero field with a moving cell still reports the speed.
        c = fill_cell(32'h0003_0000); c[0] = '0; c[1] = '0; c[2] = '0;
        send_cell(c);
        // Nonzero field with zero pressure.
        c = fill_cell('0); c[0] = 32'h0001_0000; c[3] = 32'h0002_0000; c[4] = 32'h0001_0000;
        send_cell(c);
        // Tiny parallel pressure with large trace saturates the anisotropy.
        c = fill_cell('0); c[0] = 32'h0000_0001; c[6] = 32'h0000_0001;
        c[9] = 32'h7FFF_FFFF; c[11] = 32'h7FFF_FFFF;
        send_cell(c);
        c[6] = 32'hFFFF_FFFF;
        send_cell(c);
        // Isotropic pressure: anisotropy zero.
        c = fill_cell('0); c[2] = 32'h0002_0000; c[5] = 32'h0001_0000;
        c[6] = 32'h0001_0000; c[9] = 32'h0001_0000; c[11] = 32'h0001_0000;
        send_cell(c);
        // Strongly parallel pressure gives a negative anisotropy.
        c[11] = 32'h0010_0000;
        send_cell(c);
        // Velocity exactly along the field: no perpendicular speed.
        c = fill_cell('0); c[0] = 32'h0003_0000; c[1] = 32'h0004_0000;
        c[3] = 32'h0006_0000; c[4] = 32'h0008_0000; c[6] = 32'h0001_0000;
        send_cell(c);
        c[3] = 32'hFFFA_0000; c[4] = 32'hFFF8_0000;
        send_cell(c);
        // Tiny field with a huge velocity drives the parallel speed to its signed limits.
        c = fill_cell(32'h7FFF_FFFF); c[0] = 32'h0000_0001; c[1] = '0; c[2] = '0;
        send_cell(c);
        c[3] = 32'h8000_0000;
        send_cell(c);
        // Negative field with mixed pressures.
        c = fill_cell(32'h8000_0000); c[6] = 32'h7FFF_FFFF; c[9] = 32'h0000_0001;
        send_cell(c);
        for (int k = 0; k < 12; k++) begin
            c = fill_cell('0); c[k] = 32'h8000_0001; c[(k + 1) % 3] = 32'h0001_0000;
            send_cell(c);
        end
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        src_idle_pct = idle;
        sink_stall_pct = stall;
        for (int n = 0; n < count; n++) send_cell(rand_cell());
    endtask

    // The sink holds off long enough for the pipeline to fill and stall its input.
    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_seq++;
        for (int n = 0; n < 2 * LATENCY + 20; n++) send_cell(rand_cell());
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        test_random(140, 0, 0);
        test_random(140, 71, 0);
        test_random(140, 0, 71);
        test_random(140, 37, 37);
        test_backpressure();
        s_tvalid = 1'b0;
        sink_stall_pct = 0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (LATENCY + 20) @(negedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
